// ----- design/rgbcf_pkg.sv -----
`default_nettype none
package rgbcf_pkg;
   localparam int DefMaxWidth  = 1024;
   localparam int DefMaxHeight = 1024;
   localparam int DefWeightBits = 8;
   localparam int KernelSize = 3;
   localparam int PixBits = 8;
   localparam int CsrDataBits = 24;
   localparam int CsrIndexBits = 3;
   localparam int SizeBits = 11;
   localparam int PosBits = 10;
   localparam int QueueDepth = 4;

   typedef enum logic [CsrIndexBits-1:0] {
      CSR_KERNEL_TOP    = 3'd0,
      CSR_KERNEL_MIDDLE = 3'd1,
      CSR_KERNEL_BOTTOM = 3'd2,
      CSR_DIVISOR       = 3'd3,
      CSR_WIDTH         = 3'd4,
      CSR_HEIGHT        = 3'd5
   } csr_index_type;

   typedef logic [PixBits-1:0] pix_type;

   // One 3x3 neighborhood of RGB pixels plus its position tag.
   typedef struct packed {
      logic [8:0][3*PixBits-1:0] window;
      logic [PosBits-1:0]        row;
      logic [PosBits-1:0]        col;
      logic                      last;
   } job_type;

   typedef struct packed {
      pix_type            red;
      pix_type            green;
      pix_type            blue;
      logic [PosBits-1:0] row;
      logic [PosBits-1:0] col;
      logic               last;
   } result_type;
endpackage
`default_nettype wire

// ----- design/rgbcf_if.sv -----
`default_nettype none
interface rgbcf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_in;
   logic [7:0] green_in;
   logic [7:0] blue_in;
   modport source (output valid, red_in, green_in, blue_in, input ready);
   modport sink (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface rgbcf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_out;
   logic [7:0] green_out;
   logic [7:0] blue_out;
   logic [9:0] out_row;
   logic [9:0] out_col;
   logic       last_of_frame;
   modport source (output valid, red_out, green_out, blue_out, out_row, out_col,
                   last_of_frame, input ready);
   modport sink (input valid, red_out, green_out, blue_out, out_row, out_col,
                 last_of_frame, output ready);
endinterface
`default_nettype wire

// ----- design/rgb_3x3_convolution_filter.sv -----
`default_nettype none
// Path: the front stage loads a pixel at the edge that accepts it; its job then
// passes the job queue and five back-end stages before its result is valid,
// and an output stall holds it there longer.
// Throughput: one pixel per cycle unless a back-end stall fills the job queue.
// Reset: synchronous, active high; clears counters, queue and pipeline
// valids and loads the identity kernel, divisor 1 and a 1024x1024 frame.
module rgb_3x3_convolution_filter #(
   parameter int MaxWidth   = rgbcf_pkg::DefMaxWidth,
   parameter int MaxHeight  = rgbcf_pkg::DefMaxHeight
) (
   input  wire logic clock,
   input  wire logic reset,
   rgbcf_req_if.sink   req,
   rgbcf_rsp_if.source rsp,
   input  wire logic csr_write_enable,
   input  wire logic [rgbcf_pkg::CsrIndexBits-1:0] csr_index,
   input  wire logic [rgbcf_pkg::CsrDataBits-1:0] csr_write_data
);
   import rgbcf_pkg::*;
   localparam int KBits = 3 * DefWeightBits;

   logic [CsrDataBits-1:0] k_top_ff, k_mid_ff, k_bot_ff;
   logic [7:0] div_ff;
   logic [SizeBits-1:0] width_ff, height_ff;
   logic accept, job_valid, q_valid, q_pop, back_ready, q_full;
   logic [$clog2(QueueDepth+1)-1:0] q_count;
   job_type job, q_job;
   result_type res;

   // Configuration registers, kernel rows masked to three weights.
   always_ff @(posedge clock) begin
      if (reset) begin
         k_top_ff <= '0;
         k_mid_ff <= CsrDataBits'(KBits'(256));
         k_bot_ff <= '0;
         div_ff <= 8'd1;
         width_ff <= SizeBits'(1024);
         height_ff <= SizeBits'(1024);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_KERNEL_TOP:    k_top_ff <= CsrDataBits'(csr_write_data[KBits-1:0]);
            CSR_KERNEL_MIDDLE: k_mid_ff <= CsrDataBits'(csr_write_data[KBits-1:0]);
            CSR_KERNEL_BOTTOM: k_bot_ff <= CsrDataBits'(csr_write_data[KBits-1:0]);
            CSR_DIVISOR:       div_ff <= csr_write_data[7:0];
            CSR_WIDTH:         width_ff <= csr_write_data[SizeBits-1:0];
            CSR_HEIGHT:        height_ff <= csr_write_data[SizeBits-1:0];
            default: ;
         endcase
      end
   end

   // Room for two in-flight front beats keeps the queue from overflowing.
   assign q_full = q_count > ($clog2(QueueDepth+1))'(QueueDepth - 3);
   assign req.ready = !q_full;
   assign accept = req.valid && req.ready;

   rgbcf_front #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight)) u_front (
      .clock, .reset,
      .px_valid(accept),
      .px_data({req.blue_in, req.green_in, req.red_in}),
      .width(width_ff), .height(height_ff),
      .job_valid, .job
   );

   rgbcf_queue u_queue (
      .clock, .reset,
      .push(job_valid), .push_data(job),
      .pop_valid(q_valid), .pop(q_pop), .pop_data(q_job),
      .count(q_count)
   );

   assign q_pop = q_valid && back_ready;

   rgbcf_back u_back (
      .clock, .reset,
      .job_valid(q_pop), .job_ready(back_ready), .job(q_job),
      .k_top(k_top_ff), .k_mid(k_mid_ff), .k_bot(k_bot_ff),
      .divisor(div_ff),
      .res_valid(rsp.valid), .res_ready(rsp.ready), .res
   );

   assign rsp.red_out       = res.red;
   assign rsp.green_out     = res.green;
   assign rsp.blue_out      = res.blue;
   assign rsp.out_row       = res.row;
   assign rsp.out_col       = res.col;
   assign rsp.last_of_frame = res.last;
endmodule
`default_nettype wire

// ----- design/rgbcf_front.sv -----
`default_nettype none
// Front end: line stores, window shift and position tracking. Takes one
// pixel per cycle; interior positions are pushed to the job queue.
module rgbcf_front #(
   parameter int MaxWidth  = rgbcf_pkg::DefMaxWidth,
   parameter int MaxHeight = rgbcf_pkg::DefMaxHeight
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         px_valid,
   input  wire logic [3*rgbcf_pkg::PixBits-1:0] px_data,
   input  wire logic [rgbcf_pkg::SizeBits-1:0] width,
   input  wire logic [rgbcf_pkg::SizeBits-1:0] height,
   output      logic                         job_valid,
   output      rgbcf_pkg::job_type           job
);
   import rgbcf_pkg::*;
   localparam int AddrBits = $clog2(MaxWidth);
   localparam int CntBits  = $clog2(MaxWidth > MaxHeight ? MaxWidth + 1 : MaxHeight + 1);
   localparam int PW = 3 * PixBits;

   logic [PW-1:0] upper_mem [MaxWidth];
   logic [PW-1:0] lower_mem [MaxWidth];
   logic [CntBits-1:0] col_ff, col_in, row_ff, row_in;
   logic [CntBits-1:0] w_eff, h_eff;

   // Stage one registers: the incoming pixel and read-back of both stores.
   logic          s1_valid_ff;
   logic [PW-1:0] s1_cur_ff, s1_up_ff, s1_lo_ff;
   logic [CntBits-1:0] s1_col_ff, s1_row_ff;
   logic          s1_emit_ff, s1_last_ff;
   logic [8:0][PW-1:0] win_ff;
   logic emit, last;

   // Effective frame size, zero taken as one and large values saturated.
   always_comb begin
      if (width == '0) w_eff = CntBits'(1);
      else if (32'(width) > MaxWidth) w_eff = CntBits'(MaxWidth);
      else w_eff = CntBits'(width);
      if (height == '0) h_eff = CntBits'(1);
      else if (32'(height) > MaxHeight) h_eff = CntBits'(MaxHeight);
      else h_eff = CntBits'(height);
   end

   // Position counters and interior test.
   always_comb begin
      emit = (row_ff >= CntBits'(2)) && (col_ff >= CntBits'(2)) &&
             (row_ff < h_eff) && (col_ff < w_eff);
      last = (row_ff + CntBits'(1) == h_eff) && (col_ff + CntBits'(1) == w_eff);
      col_in = col_ff;
      row_in = row_ff;
      if (px_valid) begin
         col_in = col_ff + CntBits'(1);
         if (col_in >= w_eff) begin
            col_in = '0;
            row_in = row_ff + CntBits'(1);
            if (row_in >= h_eff) row_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         s1_valid_ff <= px_valid;
      end
   end

   // Line stores: read old rows, then move lower row up and store the pixel.
   always_ff @(posedge clock) begin
      if (px_valid && col_ff < CntBits'(MaxWidth)) begin
         s1_up_ff <= upper_mem[col_ff[AddrBits-1:0]];
         s1_lo_ff <= lower_mem[col_ff[AddrBits-1:0]];
         upper_mem[col_ff[AddrBits-1:0]] <= lower_mem[col_ff[AddrBits-1:0]];
         lower_mem[col_ff[AddrBits-1:0]] <= px_data;
      end else if (px_valid) begin
         s1_up_ff <= '0;
         s1_lo_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (px_valid) begin
         s1_cur_ff  <= px_data;
         s1_col_ff  <= col_ff;
         s1_row_ff  <= row_ff;
         s1_emit_ff <= emit;
         s1_last_ff <= last;
      end
   end

   // Window shift: index row*3+col, rightmost column takes new data.
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         for (int j = 0; j < 3; j++) begin
            win_ff[j*3]   <= win_ff[j*3+1];
            win_ff[j*3+1] <= win_ff[j*3+2];
         end
         win_ff[2] <= s1_up_ff;
         win_ff[5] <= s1_lo_ff;
         win_ff[8] <= s1_cur_ff;
      end
   end

   always_comb begin
      job.window = win_ff;
      job.window[2] = s1_up_ff;
      job.window[5] = s1_lo_ff;
      job.window[8] = s1_cur_ff;
      for (int j = 0; j < 3; j++) begin
         job.window[j*3]   = win_ff[j*3+1];
         job.window[j*3+1] = win_ff[j*3+2];
      end
      job.row  = PosBits'(s1_row_ff - CntBits'(1));
      job.col  = PosBits'(s1_col_ff - CntBits'(1));
      job.last = s1_last_ff;
      job_valid = s1_valid_ff && s1_emit_ff;
   end
endmodule
`default_nettype wire

// ----- design/rgbcf_queue.sv -----
`default_nettype none
// Small job queue between front and back end.
module rgbcf_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire rgbcf_pkg::job_type push_data,
   output      logic               pop_valid,
   input  wire logic               pop,
   output      rgbcf_pkg::job_type pop_data,
   output      logic [$clog2(rgbcf_pkg::QueueDepth+1)-1:0] count
);
   import rgbcf_pkg::*;
   localparam int PtrBits = $clog2(QueueDepth);
   job_type mem_ff [QueueDepth];
   logic [PtrBits-1:0] wr_ff, rd_ff;
   logic [PtrBits:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + PtrBits'(1);
         if (pop) rd_ff <= rd_ff + PtrBits'(1);
         cnt_ff <= cnt_ff + (PtrBits+1)'(push) - (PtrBits+1)'(pop);
      end
   end

   assign pop_valid = cnt_ff != '0;
   assign pop_data  = mem_ff[rd_ff];
   assign count     = cnt_ff;
endmodule
`default_nettype wire

// ----- design/rgbcf_back.sv -----
`default_nettype none
// Back end: multiply, sum tree, divide by reciprocal, clamp. Pipelined,
// with a stall that freezes every stage when the output is blocked.
module rgbcf_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               job_valid,
   output      logic               job_ready,
   input  wire rgbcf_pkg::job_type job,
   input  wire logic [rgbcf_pkg::CsrDataBits-1:0] k_top,
   input  wire logic [rgbcf_pkg::CsrDataBits-1:0] k_mid,
   input  wire logic [rgbcf_pkg::CsrDataBits-1:0] k_bot,
   input  wire logic [7:0]         divisor,
   output      logic               res_valid,
   input  wire logic               res_ready,
   output      rgbcf_pkg::result_type res
);
   import rgbcf_pkg::*;
   localparam int WeightBits = DefWeightBits;
   localparam int ProdBits = PixBits + WeightBits + 1;
   localparam int SumBits  = ProdBits + 4;
   localparam int MagBits  = SumBits;
   localparam int RecBits  = 17;
   localparam int Stages   = 5;

   // Rounded-up reciprocal ceil(2^16/d); a one-step correction fixes the quotient.
   function automatic logic [RecBits-1:0] recip(input logic [7:0] d);
      logic [RecBits-1:0] r;
      r = RecBits'((32'h10000 + 32'(d) - 32'd1) / 32'(d == 0 ? 8'd1 : d));
      return r;
   endfunction

   logic [RecBits-1:0] rec_table [256];
   always_comb begin
      for (int i = 0; i < 256; i++) rec_table[i] = recip(8'(i));
   end

   logic stall;
   logic [Stages-1:0] v_ff;
   logic [PosBits-1:0] row_ff [Stages];
   logic [PosBits-1:0] col_ff [Stages];
   logic last_ff [Stages];

   logic signed [ProdBits-1:0] prod_ff [3][9];
   logic signed [SumBits-1:0]  sum_ff [3];
   logic [MagBits-1:0]         mag_ff [3];
   logic                       neg_ff [3];
   logic [MagBits+RecBits-1:0] qraw_ff [3];
   logic                       neg2_ff [3];
   logic [MagBits-1:0]         mag2_ff [3];
   pix_type                    out_ff [3];
   logic [7:0] d_eff;
   logic signed [WeightBits-1:0] wgt [9];

   assign d_eff = (divisor == '0) ? 8'd1 : divisor;
   assign stall = v_ff[Stages-1] && !res_ready;
   assign job_ready = !stall;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         wgt[i]   = k_top[i*WeightBits +: WeightBits];
         wgt[3+i] = k_mid[i*WeightBits +: WeightBits];
         wgt[6+i] = k_bot[i*WeightBits +: WeightBits];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (!stall) v_ff <= {v_ff[Stages-2:0], job_valid};
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         row_ff[0] <= job.row;
         col_ff[0] <= job.col;
         last_ff[0] <= job.last;
         for (int s = 1; s < Stages; s++) begin
            row_ff[s] <= row_ff[s-1];
            col_ff[s] <= col_ff[s-1];
            last_ff[s] <= last_ff[s-1];
         end
         // Stage 0: 27 small products.
         for (int p = 0; p < 3; p++)
            for (int k = 0; k < 9; k++)
               prod_ff[p][k] <= $signed({1'b0, job.window[k][p*PixBits +: PixBits]}) *
                                ProdBits'(wgt[k]);
         // Stage 1: sum of nine.
         for (int p = 0; p < 3; p++) begin
            sum_ff[p] <= SumBits'(prod_ff[p][0]) + SumBits'(prod_ff[p][1]) +
                         SumBits'(prod_ff[p][2]) + SumBits'(prod_ff[p][3]) +
                         SumBits'(prod_ff[p][4]) + SumBits'(prod_ff[p][5]) +
                         SumBits'(prod_ff[p][6]) + SumBits'(prod_ff[p][7]) +
                         SumBits'(prod_ff[p][8]);
         end
         // Stage 2: sign and magnitude.
         for (int p = 0; p < 3; p++) begin
            neg_ff[p] <= sum_ff[p][SumBits-1];
            mag_ff[p] <= sum_ff[p][SumBits-1] ? MagBits'(-sum_ff[p]) : MagBits'(sum_ff[p]);
         end
         // Stage 3: reciprocal multiply.
         for (int p = 0; p < 3; p++) begin
            qraw_ff[p] <= (MagBits+RecBits)'(mag_ff[p]) *
                          (MagBits+RecBits)'(rec_table[d_eff]);
            neg2_ff[p] <= neg_ff[p];
            mag2_ff[p] <= mag_ff[p];
         end
         // Stage 4: correct quotient, then clamp.
         for (int p = 0; p < 3; p++) begin
            logic [MagBits-1:0] q;
            logic [MagBits+8:0] qd;
            q = MagBits'(qraw_ff[p] >> 16);
            qd = (MagBits+9)'(q) * (MagBits+9)'(d_eff);
            if (qd > (MagBits+9)'(mag2_ff[p])) q = q - MagBits'(1);
            if (neg2_ff[p] || q == '0) out_ff[p] <= '0;
            else if (q > MagBits'(255)) out_ff[p] <= 8'd255;
            else out_ff[p] <= q[7:0];
         end
      end
   end

   assign res_valid = v_ff[Stages-1];
   assign res.red   = out_ff[0];
   assign res.green = out_ff[1];
   assign res.blue  = out_ff[2];
   assign res.row   = row_ff[Stages-1];
   assign res.col   = col_ff[Stages-1];
   assign res.last  = last_ff[Stages-1];
endmodule
`default_nettype wire

// ----- design/rgbcf_checker.sv -----
`default_nettype none
// Port-level checks on the result channel.
module rgbcf_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [7:0] rsp_red,
   input wire logic [9:0] rsp_row,
   input wire logic [9:0] rsp_col,
   input wire logic rsp_last
);
   // A stalled result holds its beat.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red) && $stable(rsp_row))
      else $error("result changed while stalled");
   // Interior positions never touch row or column zero.
   a_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_row != 10'd0 && rsp_col != 10'd0)
      else $error("border position emitted");
   // Nothing emitted right after a reset cycle.
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result after reset");
   // An end-of-frame beat sits at an interior column.
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_col >= 10'd1)
      else $error("bad end of frame");
endmodule

bind rgb_3x3_convolution_filter rgbcf_checker u_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_red(rsp.red_out),
   .rsp_row(rsp.out_row), .rsp_col(rsp.out_col), .rsp_last(rsp.last_of_frame)
);
`default_nettype wire

// ----- verif/rgb_3x3_convolution_filter_tb.sv -----
`default_nettype none
module rgb_3x3_convolution_filter_tb;
   import rgbcf_pkg::*;

   // One directed pixel, with its expected result typed in where obvious.
   typedef struct packed {
      pix_type    red;
      pix_type    green;
      pix_type    blue;
      logic       typed;
      result_type want;
   } pixel_row_type;

   localparam int DrainCycles = 16;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [CsrIndexBits-1:0] csr_index;
   logic [CsrDataBits-1:0] csr_write_data;

   rgbcf_req_if req_if ();
   rgbcf_rsp_if rsp_if ();

   rgb_3x3_convolution_filter dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_if),
      .rsp              (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Shadow copy of the filter state and its registers.
   logic [3*PixBits-1:0] upper_line [DefMaxWidth];
   logic [3*PixBits-1:0] lower_line [DefMaxWidth];
   logic [3*PixBits-1:0] window [3][3];
   logic [CsrDataBits-1:0] kernel_rows [3];
   int divisor_value;
   int frame_width;
   int frame_height;
   int col_pos;
   int row_pos;

   result_type filtered_q [$];
   int mismatches;
   int send_idle_pct;
   int recv_stall_pct;

   pixel_row_type directed_rows [18] = '{
      // Identity kernel: the result is the center pixel.
      '{8'd0,   8'd0,   8'd0,   1'b0, '0},
      '{8'd255, 8'd255, 8'd255, 1'b0, '0},
      '{8'd0,   8'd255, 8'd0,   1'b0, '0},
      '{8'd255, 8'd0,   8'd0,   1'b0, '0},
      '{8'd255, 8'd0,   8'd128, 1'b0, '0},
      '{8'd0,   8'd0,   8'd255, 1'b0, '0},
      '{8'd1,   8'd2,   8'd3,   1'b0, '0},
      '{8'd128, 8'd127, 8'd254, 1'b0, '0},
      '{8'd255, 8'd255, 8'd255, 1'b1,
        '{8'd255, 8'd0, 8'd128, 10'd1, 10'd1, 1'b1}},
      // All weights minus one: every sum is negative and clamps to zero.
      '{8'd255, 8'd255, 8'd255, 1'b0, '0},
      '{8'd255, 8'd1,   8'd255, 1'b0, '0},
      '{8'd255, 8'd255, 8'd255, 1'b0, '0},
      '{8'd0,   8'd255, 8'd255, 1'b0, '0},
      '{8'd255, 8'd255, 8'd128, 1'b0, '0},
      '{8'd255, 8'd255, 8'd255, 1'b0, '0},
      '{8'd255, 8'd0,   8'd255, 1'b0, '0},
      '{8'd255, 8'd255, 8'd255, 1'b0, '0},
      '{8'd255, 8'd255, 8'd255, 1'b1,
        '{8'd0, 8'd0, 8'd0, 10'd1, 10'd1, 1'b1}}
   };

   // Clock.
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Weighted sum of one color plane, divided toward zero and clamped.
   function automatic pix_type filter_plane(input int shift);
      longint sum;
      longint d;
      logic signed [7:0] weight;
      sum = 0;
      d = (divisor_value == 0) ? 1 : longint'(divisor_value);
      for (int j = 0; j < 3; j++) begin
         for (int i = 0; i < 3; i++) begin
            weight = kernel_rows[j][i*8 +: 8];
            sum += longint'(window[j][i][shift +: 8]) * longint'(weight);
         end
      end
      sum = sum / d;
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > 255) begin
         sum = 255;
      end
      return pix_type'(sum);
   endfunction

   // Advance the shadow state by one pixel and work out its result, if any.
   task automatic filter_pixel(input pix_type r, input pix_type g, input pix_type b,
                               output bit emitted, output result_type res);
      logic [3*PixBits-1:0] cur;
      logic [3*PixBits-1:0] up;
      logic [3*PixBits-1:0] lo;
      int w;
      int h;
      w = (frame_width == 0) ? 1 : (frame_width > DefMaxWidth) ? DefMaxWidth : frame_width;
      h = (frame_height == 0) ? 1 :
          (frame_height > DefMaxHeight) ? DefMaxHeight : frame_height;
      cur = {b, g, r};
      up = upper_line[col_pos];
      lo = lower_line[col_pos];
      upper_line[col_pos] = lo;
      lower_line[col_pos] = cur;
      for (int j = 0; j < 3; j++) begin
         window[j][0] = window[j][1];
         window[j][1] = window[j][2];
      end
      window[0][2] = up;
      window[1][2] = lo;
      window[2][2] = cur;
      emitted = (row_pos >= 2 && col_pos >= 2 && row_pos < h && col_pos < w);
      res.red = filter_plane(0);
      res.green = filter_plane(8);
      res.blue = filter_plane(16);
      res.row = PosBits'(row_pos - 1);
      res.col = PosBits'(col_pos - 1);
      res.last = (row_pos + 1 == h && col_pos + 1 == w);
      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= h) begin
            row_pos = 0;
         end
      end
   endtask

   // Drive one pixel beat and predict it once it is accepted.
   task automatic send_pixel(input pix_type r, input pix_type g, input pix_type b,
                             output bit emitted, output result_type res);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.red_in <= r;
      req_if.green_in <= g;
      req_if.blue_in <= b;
      do begin
         @(posedge clock);
      end while (!req_if.ready);
      filter_pixel(r, g, b, emitted, res);
   endtask

   // Stop sending, wait for every expected result, then let the design idle before returning.
   task automatic drain;
      req_if.valid <= 1'b0;
      while (filtered_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [CsrDataBits-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
   endtask

   // Write every register and mirror it in the shadow copy.
   task automatic configure(input logic [23:0] k_top, input logic [23:0] k_mid,
                            input logic [23:0] k_bot, input int div, input int w,
                            input int h);
      csr_write(CSR_KERNEL_TOP, k_top);
      csr_write(CSR_KERNEL_MIDDLE, k_mid);
      csr_write(CSR_KERNEL_BOTTOM, k_bot);
      csr_write(CSR_DIVISOR, CsrDataBits'(div));
      csr_write(CSR_WIDTH, CsrDataBits'(w));
      csr_write(CSR_HEIGHT, CsrDataBits'(h));
      csr_write_enable <= 1'b0;
      kernel_rows[0] = k_top;
      kernel_rows[1] = k_mid;
      kernel_rows[2] = k_bot;
      divisor_value = div & 'hFF;
      frame_width = w & 'h7FF;
      frame_height = h & 'h7FF;
   endtask

   function automatic pix_type random_pix;
      if ($urandom_range(0, 3) == 0) begin
         return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
      end
      return pix_type'($urandom);
   endfunction

   // Either fully random weights or small ones that keep sums in range.
   function automatic logic [23:0] random_kernel_row;
      logic [23:0] row;
      if ($urandom_range(0, 2) == 0) begin
         return 24'($urandom);
      end
      for (int k = 0; k < 3; k++) begin
         row[k*8 +: 8] = 8'($urandom_range(0, 8) - 3);
      end
      return row;
   endfunction

   // Send whole frames; optionally hold off once midway until all results are in.
   task automatic send_frames(input int frames, input bit hold_off);
      bit emitted;
      result_type res;
      int count;
      count = frames * frame_width * frame_height;
      for (int n = 0; n < count; n++) begin
         if (hold_off && n == count / 2) begin
            drain;
         end
         send_pixel(random_pix(), random_pix(), random_pix(), emitted, res);
         if (emitted) begin
            filtered_q.push_back(res);
         end
      end
      drain;
   endtask

   // Result side: random stalls and field by field checking of each beat.
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = '{rsp_if.red_out, rsp_if.green_out, rsp_if.blue_out,
                    rsp_if.out_row, rsp_if.out_col, rsp_if.last_of_frame};
            if (filtered_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("Unexpected result beat: %p", got);
               end
            end else begin
               want = filtered_q.pop_front();
               if (got.red !== want.red || got.green !== want.green ||
                   got.blue !== want.blue || got.row !== want.row ||
                   got.col !== want.col || got.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("Result mismatch: expected %p, got %p", want, got);
                  end
               end
            end
         end
         rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Stimulus.
   initial begin
      bit emitted;
      result_type res;
      int idle_modes [4][2] = '{'{0, 0}, '{64, 0}, '{0, 64}, '{34, 34}};
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.red_in = '0;
      req_if.green_in = '0;
      req_if.blue_in = '0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      mismatches = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      kernel_rows = '{24'd0, 24'd256, 24'd0};
      divisor_value = 1;
      frame_width = DefMaxWidth;
      frame_height = DefMaxHeight;
      col_pos = 0;
      row_pos = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frames of the smallest size that yields a result.
      configure(24'd0, 24'd256, 24'd0, 1, 3, 3);
      for (int i = 0; i < 18; i++) begin
         if (i == 9) begin
            drain;
            configure(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1, 3, 3);
         end
         send_pixel(directed_rows[i].red, directed_rows[i].green,
                    directed_rows[i].blue, emitted, res);
         if (emitted) begin
            filtered_q.push_back(directed_rows[i].typed ? directed_rows[i].want : res);
         end
      end
      drain;
      // Largest positive weights, then mostly most negative ones.
      configure(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 255, 4, 3);
      send_frames(1, 1'b0);
      configure(24'h808080, 24'h7F8080, 24'h808080, 1, 3, 4);
      send_frames(1, 1'b0);

      // Random settings of small frames under each idling pattern.
      for (int mode = 0; mode < 4; mode++) begin
         send_idle_pct = idle_modes[mode][0];
         recv_stall_pct = idle_modes[mode][1];
         for (int s = 0; s < 4; s++) begin
            configure(random_kernel_row(), random_kernel_row(), random_kernel_row(),
                      ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 255),
                      $urandom_range(3, 12), $urandom_range(3, 10));
            send_frames(2, mode == 0 && s == 0);
         end
      end

      drain;
      if (mismatches == 0) begin
         $display("PASS rgb_3x3_convolution_filter");
      end else begin
         $display("FAIL rgb_3x3_convolution_filter");
      end
      $finish;
   end

   // Timeout.
   initial begin
      #40000000;
      $display("FAIL rgb_3x3_convolution_filter");
      $finish;
   end
endmodule
`default_nettype wire
